// ===== sv/gbn_pkg.sv =====
// Package: shared types, codes and controller/datapath link structs for the go-back-N sender.
package gbn_pkg;

  localparam int SEQ_W = 16;
  localparam int WIN_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_NACK  = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd1;

  localparam logic [SEQ_W-1:0] FRAG_COUNT_RST = 16'd0;
  localparam logic [WIN_W-1:0] WINDOW_RST     = 7'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_SEND,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_UPDATE,
    CTL_BURST
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic upd_en;
    logic burst_en;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic need_burst;
    logic burst_last;
  } dp_sts_t;

endpackage

// ===== sv/gbn_if.sv =====
// Interfaces: input, result and configuration channels of the go-back-N sender.
interface gbn_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [gbn_pkg::SEQ_W-1:0] ack_sequence;

  modport source (output valid, output cmd, output ack_sequence, input ready);
  modport sink (input valid, input cmd, input ack_sequence, output ready);
endinterface

interface gbn_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                send_kind;
  logic [gbn_pkg::SEQ_W-1:0] send_sequence;
  logic [gbn_pkg::SEQ_W-1:0] fragment_index;
  logic                      transfer_done;
  logic                      transfer_ok;
  logic                      last;

  modport source (output valid, output send_kind, output send_sequence,
                  output fragment_index, output transfer_done, output transfer_ok,
                  output last, input ready);
  modport sink (input valid, input send_kind, input send_sequence,
                input fragment_index, input transfer_done, input transfer_ok,
                input last, output ready);
endinterface

interface gbn_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbn_pkg::CFG_IDX_W-1:0]  index;
  logic [gbn_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/gbn_ctrl.sv =====
// Controller: sequences capture, state update and burst emission of DATA, END or status results.
module gbn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gbn_pkg::dp_sts_t sts,
  output gbn_pkg::dp_cmd_t cmd
);

  gbn_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbn_pkg::CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbn_pkg::CTL_IDLE: begin
        if (in_valid) state_nxt = gbn_pkg::CTL_UPDATE;
      end
      gbn_pkg::CTL_UPDATE: begin
        if (sts.slot_free) begin
          state_nxt = sts.need_burst ? gbn_pkg::CTL_BURST : gbn_pkg::CTL_IDLE;
        end
      end
      gbn_pkg::CTL_BURST: begin
        if (sts.slot_free && sts.burst_last) state_nxt = gbn_pkg::CTL_IDLE;
      end
      default: state_nxt = gbn_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.upd_en   = 1'b0;
    cmd.burst_en = 1'b0;
    unique case (state_r)
      gbn_pkg::CTL_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      gbn_pkg::CTL_UPDATE: begin
        cmd.upd_en = sts.slot_free;
      end
      gbn_pkg::CTL_BURST: begin
        cmd.burst_en = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/gbn_dp.sv =====
// Datapath: configuration, transfer state, window arithmetic and result register.
module gbn_dp #(
  parameter int MAX_WINDOW  = 64,
  parameter int END_RETRIES = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gbn_pkg::dp_cmd_t                cmd,
  output gbn_pkg::dp_sts_t                sts,
  input  logic [1:0]                      in_cmd,
  input  logic [gbn_pkg::SEQ_W-1:0]       in_ack_sequence,
  input  logic                            cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_send_kind,
  output logic [gbn_pkg::SEQ_W-1:0]       out_send_sequence,
  output logic [gbn_pkg::SEQ_W-1:0]       out_fragment_index,
  output logic                            out_transfer_done,
  output logic                            out_transfer_ok,
  output logic                            out_last
);

  localparam int SW = gbn_pkg::SEQ_W;

  logic [SW-1:0]             frag_count_r;
  logic [gbn_pkg::WIN_W-1:0] window_r;

  logic [1:0]    cmd_r;
  logic [SW-1:0] ack_r;

  gbn_pkg::phase_t phase_r, phase_nxt;
  logic [SW-1:0]   base_r, base_nxt;
  logic [SW-1:0]   next_r, next_nxt;
  logic [1:0]      attempts_r, attempts_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [SW-1:0] seq_r, seq_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          done_r, done_nxt;
  logic          ok_r, ok_nxt;
  logic          last_r, last_nxt;
  logic          ld;

  logic                      is_reply;
  logic [SW-1:0]             ack_base;
  logic [gbn_pkg::WIN_W-1:0] eff_win;
  logic [SW:0]               limit;
  logic [SW:0]               next_inc;
  logic                      can_send;
  logic                      more_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_count_r <= gbn_pkg::FRAG_COUNT_RST;
      window_r     <= gbn_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gbn_pkg::REG_FRAG_COUNT: frag_count_r <= cfg_data;
        gbn_pkg::REG_WINDOW:     window_r     <= cfg_data[gbn_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      ack_r <= in_ack_sequence;
    end
  end

  assign is_reply = (cmd_r == gbn_pkg::CMD_ACK) || (cmd_r == gbn_pkg::CMD_NACK);
  assign ack_base = (ack_r < frag_count_r) ? ack_r : frag_count_r;

  always_comb begin
    if (window_r == '0) begin
      eff_win = gbn_pkg::WIN_W'(1);
    end else if (window_r > gbn_pkg::WIN_W'(MAX_WINDOW)) begin
      eff_win = gbn_pkg::WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = window_r;
    end
  end

  assign limit      = {1'b0, base_r} + (SW+1)'(eff_win);
  assign next_inc   = {1'b0, next_r} + (SW+1)'(1);
  assign can_send   = ({1'b0, next_r} < limit) && (next_r < frag_count_r);
  assign more_after = (next_inc < limit) && (next_inc < {1'b0, frag_count_r});

  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.need_burst = is_reply &&
                          ((phase_r == gbn_pkg::PH_SEND) ||
                           ((phase_r == gbn_pkg::PH_START) && (cmd_r == gbn_pkg::CMD_ACK)));
  assign sts.burst_last = (base_r >= frag_count_r) || !can_send || !more_after;

  always_comb begin
    phase_nxt    = phase_r;
    base_nxt     = base_r;
    next_nxt     = next_r;
    attempts_nxt = attempts_r;
    ld           = 1'b0;
    kind_nxt     = gbn_pkg::KIND_STATUS;
    seq_nxt      = '0;
    idx_nxt      = '0;
    done_nxt     = 1'b0;
    ok_nxt       = 1'b0;
    last_nxt     = 1'b1;
    if (cmd.upd_en) begin
      if (cmd_r == gbn_pkg::CMD_BEGIN) begin
        phase_nxt    = gbn_pkg::PH_START;
        base_nxt     = '0;
        next_nxt     = '0;
        attempts_nxt = '0;
        ld           = 1'b1;
        kind_nxt     = gbn_pkg::KIND_START;
      end else if (!is_reply) begin
        ld = 1'b1;
      end else begin
        unique case (phase_r)
          gbn_pkg::PH_IDLE: begin
            ld = 1'b1;
          end
          gbn_pkg::PH_START: begin
            if (cmd_r == gbn_pkg::CMD_ACK) begin
              phase_nxt = gbn_pkg::PH_SEND;
              base_nxt  = '0;
              next_nxt  = '0;
            end else begin
              ld       = 1'b1;
              kind_nxt = gbn_pkg::KIND_START;
            end
          end
          gbn_pkg::PH_SEND: begin
            if (cmd_r == gbn_pkg::CMD_ACK) begin
              base_nxt = ack_base;
              if (next_r < ack_base) next_nxt = ack_base;
            end else begin
              next_nxt = base_r;
            end
          end
          gbn_pkg::PH_END: begin
            ld = 1'b1;
            if ((cmd_r == gbn_pkg::CMD_ACK) && (ack_r == '0)) begin
              phase_nxt = gbn_pkg::PH_IDLE;
              done_nxt  = 1'b1;
              ok_nxt    = 1'b1;
            end else if (attempts_r < 2'(END_RETRIES)) begin
              attempts_nxt = attempts_r + 2'd1;
              kind_nxt     = gbn_pkg::KIND_END;
            end else begin
              phase_nxt = gbn_pkg::PH_IDLE;
              done_nxt  = 1'b1;
            end
          end
          default: ld = 1'b1;
        endcase
      end
    end else if (cmd.burst_en) begin
      ld = 1'b1;
      if (base_r >= frag_count_r) begin
        phase_nxt    = gbn_pkg::PH_END;
        attempts_nxt = 2'd1;
        kind_nxt     = gbn_pkg::KIND_END;
      end else if (can_send) begin
        kind_nxt = gbn_pkg::KIND_DATA;
        seq_nxt  = next_inc[SW-1:0];
        idx_nxt  = next_r;
        next_nxt = next_inc[SW-1:0];
        last_nxt = !more_after;
      end
    end
  end

  always_comb begin
    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= gbn_pkg::PH_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      attempts_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      attempts_r  <= attempts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      kind_r <= kind_nxt;
      seq_r  <= seq_nxt;
      idx_r  <= idx_nxt;
      done_r <= done_nxt;
      ok_r   <= ok_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_send_kind      = kind_r;
  assign out_send_sequence  = seq_r;
  assign out_fragment_index = idx_r;
  assign out_transfer_done  = done_r;
  assign out_transfer_ok    = ok_r;
  assign out_last           = last_r;

endmodule

// ===== sv/go_back_n_sender.sv =====
// Top level: go-back-N ARQ sender, controller plus datapath.
//
//   channel  | dir | payload                                              | accepted when
//   in_ch    | in  | cmd, ack_sequence                                    | valid && ready
//   out_ch   | out | send_kind, send_sequence, fragment_index,            | valid && ready
//            |     | transfer_done, transfer_ok, last                     |
//   cfg_ch   | in  | index (0 fragment_count, 1 window), data             | valid && ready
//
// An item passes from its accept state through an update state; a single result is loaded in
// the update state, while a data-phase reply instead loads one result per burst cycle,
// up to MAX_WINDOW DATA results (or one END or status result).
// The single result register sets the pace: a stall on out_ch holds the burst.
// in_ch is ready again once the last result is loaded; cfg_ch is always ready.
// Reset (rst_n low, synchronous) empties the result register and returns to idle.
module go_back_n_sender #(
  parameter int MAX_WINDOW  = 64,
  parameter int END_RETRIES = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  gbn_in_if.sink    in_ch,
  gbn_out_if.source out_ch,
  gbn_cfg_if.sink   cfg_ch
);

  gbn_pkg::dp_cmd_t dp_cmd;
  gbn_pkg::dp_sts_t dp_sts;
  logic             ctl_in_ready;

  assign in_ch.ready  = ctl_in_ready;
  assign cfg_ch.ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  gbn_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .END_RETRIES (END_RETRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .sts                (dp_sts),
    .in_cmd             (in_ch.cmd),
    .in_ack_sequence    (in_ch.ack_sequence),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_send_kind      (out_ch.send_kind),
    .out_send_sequence  (out_ch.send_sequence),
    .out_fragment_index (out_ch.fragment_index),
    .out_transfer_done  (out_ch.transfer_done),
    .out_transfer_ok    (out_ch.transfer_ok),
    .out_last           (out_ch.last)
  );

endmodule
